>>> rtl/core/irs_pkg.sv
// irs_pkg: shared types and constants of the rendezvous message engine
// holds the process record layout, command codes and status codes
// no dependencies
package irs_pkg;

  localparam int unsigned PID_W  = 4;
  localparam int unsigned LINK_W = 5;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned TICK_W = 8;

  // command codes
  typedef enum logic [2:0] {
    CMD_SEND  = 3'd0,
    CMD_RECV  = 3'd1,
    CMD_SCHED = 3'd2,
    CMD_POST  = 3'd3,
    CMD_LOAD  = 3'd4,
    CMD_TICK  = 3'd5
  } cmd_e;

  // result status codes
  localparam logic [2:0] STS_DELIVERED = 3'd0;
  localparam logic [2:0] STS_BLOCKED   = 3'd1;
  localparam logic [2:0] STS_DEADLOCK  = 3'd2;
  localparam logic [2:0] STS_INT       = 3'd3;
  localparam logic [2:0] STS_DONE      = 3'd4;
  localparam logic [2:0] STS_IDLE_ALL  = 3'd5;

  // process states
  localparam logic [1:0] PS_RUN  = 2'd0;
  localparam logic [1:0] PS_SEND = 2'd1;
  localparam logic [1:0] PS_RECV = 2'd2;

  // special peer and link codes
  localparam logic [LINK_W-1:0] PEER_ANY = 5'd16;
  localparam logic [LINK_W-1:0] PEER_INT = 5'd17;
  localparam logic [LINK_W-1:0] NO_LINK  = 5'd16;

  // one process record, kept as one memory word
  typedef struct packed {
    logic [1:0]        proc_state;
    logic [PID_W-1:0]  send_target;
    logic [LINK_W-1:0] recv_source;
    logic              int_pending;
    logic [LINK_W-1:0] queue_head;
    logic [LINK_W-1:0] queue_next;
    logic [TAG_W-1:0]  buffer_tag;
    logic [TICK_W-1:0] tick_left;
    logic [TICK_W-1:0] prio;
  } rec_t;

  localparam rec_t REC_RESET = '{
    proc_state:  PS_RUN,
    send_target: '0,
    recv_source: '0,
    int_pending: 1'b0,
    queue_head:  NO_LINK,
    queue_next:  NO_LINK,
    buffer_tag:  '0,
    tick_left:   '0,
    prio:        '0
  };

endpackage

>>> rtl/core/ipc_rendezvous_scheduler.sv
// ipc_rendezvous_scheduler: rendezvous message engine with tick scheduler, all process
// records in one synchronous memory handled read-modify-write; depends on irs_pkg
// flow: ignored commands go straight to output; load, post and tick read then write the record;
// a walk reads one record per chain or queue link, and each scan or refill visits every process
// throughput: one command at a time, input held off until its result is registered
// reset: records read as reset value until written (valid bit per entry); running is 0
module ipc_rendezvous_scheduler #(
  parameter int unsigned NUM_TASKS = 4,
  parameter int unsigned NUM_USER  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], caller[6:3], peer[11:7], msg_tag[27:12], value[35:28], zero pad
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], from_pid[7:3], to_pid[11:8], delivered_tag[27:12],
  // ready_pid[31:28]
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned NSUM  = NUM_TASKS + NUM_USER;
  localparam int unsigned NPROC = (NSUM > 16) ? 16 : NSUM;
  localparam logic [irs_pkg::PID_W-1:0]  LAST_PID = irs_pkg::PID_W'(NPROC - 1);
  localparam logic [irs_pkg::LINK_W-1:0] NPROC_L  = irs_pkg::LINK_W'(NPROC);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_LOAD, S_POST, S_TICK, S_SND_CHK, S_CYC, S_SND_PEER,
    S_ENQ_HEAD, S_ENQ_WALK, S_RCV_CHK, S_RCV_PEER, S_UNL, S_SRC, S_SCAN,
    S_REFILL, S_OUT
  } state_e;

  // process record memory
  irs_pkg::rec_t mem_q [16];
  irs_pkg::rec_t rd_q;
  logic          rd_vld_q;
  logic [15:0]   vld_q;

  logic                       rd_en, we;
  logic [irs_pkg::PID_W-1:0]  rd_addr, waddr;
  irs_pkg::rec_t              wdata, rec;

  state_e state_q, state_d;
  logic [2:0]                 cmd_q, cmd_d;
  logic [irs_pkg::PID_W-1:0]  caller_q, caller_d;
  logic [irs_pkg::LINK_W-1:0] peer_q, peer_d;
  logic [irs_pkg::TAG_W-1:0]  tag_q, tag_d;
  logic [irs_pkg::TICK_W-1:0] value_q, value_d;
  irs_pkg::rec_t              caller_rec_q, caller_rec_d, prev_rec_q, prev_rec_d;
  logic [irs_pkg::LINK_W-1:0] p_q, p_d, prev_q, prev_d, n_q, n_d;
  logic [irs_pkg::PID_W-1:0]  src_q, src_d, idx_q, idx_d, who_q, who_d;
  logic [irs_pkg::TICK_W-1:0] best_q, best_d;
  logic                       pass_q, pass_d, found_q, found_d;
  logic [2:0]                 ok_q, ok_d, fail_q, fail_d;
  logic [irs_pkg::PID_W-1:0]  running_q, running_d;
  logic [2:0]                 sts_q, sts_d;
  logic [irs_pkg::LINK_W-1:0] from_q, from_d;
  logic [irs_pkg::PID_W-1:0]  to_q, to_d;
  logic [irs_pkg::TAG_W-1:0]  dtag_q, dtag_d;
  logic                       out_vld_q, out_vld_d;
  logic [31:0]                out_q, out_d;

  // scratch values of the control logic
  logic                       go_sched, caller_ok, peer_in, s_take;
  logic [irs_pkg::TICK_W-1:0] best_n;
  logic [irs_pkg::PID_W-1:0]  who_n;
  irs_pkg::rec_t              blk_rec;

  assign rec           = rd_vld_q ? rd_q : irs_pkg::REC_RESET;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_take        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign caller_ok     = {1'b0, caller_q} < NPROC_L;
  assign peer_in       = (peer_q < NPROC_L) && (peer_q != {1'b0, caller_q});

  // memory with one write and one read port, write data forwarded to read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= (we && waddr == rd_addr) ? wdata : mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= (we && waddr == rd_addr) ? 1'b1 : vld_q[rd_addr];
      end
    end
  end

  // command sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    caller_d     = caller_q;
    peer_d       = peer_q;
    tag_d        = tag_q;
    value_d      = value_q;
    caller_rec_d = caller_rec_q;
    prev_rec_d   = prev_rec_q;
    p_d          = p_q;
    prev_d       = prev_q;
    n_d          = n_q;
    src_d        = src_q;
    idx_d        = idx_q;
    who_d        = who_q;
    best_d       = best_q;
    pass_d       = pass_q;
    found_d      = found_q;
    ok_d         = ok_q;
    fail_d       = fail_q;
    running_d    = running_q;
    sts_d        = sts_q;
    from_d       = from_q;
    to_d         = to_q;
    dtag_d       = dtag_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_d        = out_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = rec;
    go_sched     = 1'b0;
    best_n       = best_q;
    who_n        = who_q;
    blk_rec      = caller_rec_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_take) begin
          cmd_d    = s_axis_tdata[2:0];
          caller_d = s_axis_tdata[6:3];
          peer_d   = s_axis_tdata[11:7];
          tag_d    = s_axis_tdata[27:12];
          value_d  = s_axis_tdata[35:28];
          sts_d    = irs_pkg::STS_DONE;
          from_d   = '0;
          to_d     = '0;
          dtag_d   = '0;
          state_d  = S_DISP;
        end
      end

      S_DISP: begin
        state_d = S_OUT;
        rd_addr = caller_q;
        unique case (cmd_q)
          irs_pkg::CMD_SEND: begin
            if (caller_ok && peer_in) begin
              rd_en   = 1'b1;
              state_d = S_SND_CHK;
            end
          end
          irs_pkg::CMD_RECV: begin
            if (caller_ok && (peer_q == irs_pkg::PEER_ANY ||
                              peer_q == irs_pkg::PEER_INT || peer_in)) begin
              rd_en   = 1'b1;
              state_d = S_RCV_CHK;
            end
          end
          irs_pkg::CMD_SCHED: begin
            ok_d     = irs_pkg::STS_DONE;
            fail_d   = irs_pkg::STS_IDLE_ALL;
            go_sched = 1'b1;
          end
          irs_pkg::CMD_POST: begin
            if (caller_ok) begin
              rd_en   = 1'b1;
              state_d = S_POST;
            end
          end
          irs_pkg::CMD_LOAD: begin
            if (caller_ok) begin
              rd_en   = 1'b1;
              state_d = S_LOAD;
            end
          end
          irs_pkg::CMD_TICK: begin
            rd_en   = 1'b1;
            rd_addr = running_q;
            state_d = S_TICK;
          end
          default: ;
        endcase
      end

      // priority load
      S_LOAD: begin
        we         = 1'b1;
        waddr      = caller_q;
        wdata.prio = value_q;
        state_d    = S_OUT;
      end

      // interrupt post
      S_POST: begin
        we      = 1'b1;
        waddr   = caller_q;
        state_d = S_OUT;
        if (rec.proc_state == irs_pkg::PS_RECV &&
            (rec.recv_source == irs_pkg::PEER_ANY ||
             rec.recv_source == irs_pkg::PEER_INT)) begin
          wdata.proc_state  = irs_pkg::PS_RUN;
          wdata.recv_source = '0;
          sts_d             = irs_pkg::STS_INT;
          from_d            = irs_pkg::PEER_INT;
          to_d              = caller_q;
        end else begin
          wdata.int_pending = 1'b1;
        end
      end

      // clock tick on the running process
      S_TICK: begin
        state_d = S_OUT;
        if (rec.tick_left != '0) begin
          we              = 1'b1;
          waddr           = running_q;
          wdata.tick_left = rec.tick_left - 8'd1;
          if (rec.tick_left == 8'd1) begin
            ok_d     = irs_pkg::STS_DONE;
            fail_d   = irs_pkg::STS_IDLE_ALL;
            go_sched = 1'b1;
          end
        end
      end

      // send: caller must be runnable, then walk the sender chain
      S_SND_CHK: begin
        caller_rec_d = rec;
        state_d      = S_OUT;
        if (rec.proc_state == irs_pkg::PS_RUN) begin
          rd_en   = 1'b1;
          rd_addr = peer_q[3:0];
          p_d     = peer_q;
          n_d     = '0;
          state_d = S_CYC;
        end
      end

      S_CYC: begin
        if (rec.proc_state != irs_pkg::PS_SEND || n_q == 5'd16) begin
          rd_en   = 1'b1;
          rd_addr = peer_q[3:0];
          state_d = S_SND_PEER;
        end else if (rec.send_target == caller_q) begin
          sts_d   = irs_pkg::STS_DEADLOCK;
          state_d = S_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rec.send_target;
          p_d     = {1'b0, rec.send_target};
          n_d     = n_q + 5'd1;
        end
      end

      // deliver to a waiting receiver or block on its queue
      S_SND_PEER: begin
        we = 1'b1;
        if (rec.proc_state == irs_pkg::PS_RECV &&
            (rec.recv_source == {1'b0, caller_q} ||
             rec.recv_source == irs_pkg::PEER_ANY)) begin
          waddr             = peer_q[3:0];
          wdata.proc_state  = irs_pkg::PS_RUN;
          wdata.recv_source = '0;
          sts_d             = irs_pkg::STS_DELIVERED;
          from_d            = {1'b0, caller_q};
          to_d              = peer_q[3:0];
          dtag_d            = tag_q;
          state_d           = S_OUT;
        end else begin
          waddr             = caller_q;
          wdata             = caller_rec_q;
          wdata.proc_state  = irs_pkg::PS_SEND;
          wdata.send_target = peer_q[3:0];
          wdata.buffer_tag  = tag_q;
          wdata.queue_next  = irs_pkg::NO_LINK;
          rd_en             = 1'b1;
          rd_addr           = peer_q[3:0];
          state_d           = S_ENQ_HEAD;
        end
      end

      S_ENQ_HEAD: begin
        if (rec.queue_head >= irs_pkg::NO_LINK) begin
          we               = 1'b1;
          waddr            = peer_q[3:0];
          wdata.queue_head = {1'b0, caller_q};
          sts_d            = irs_pkg::STS_BLOCKED;
          ok_d             = irs_pkg::STS_BLOCKED;
          fail_d           = irs_pkg::STS_BLOCKED;
          go_sched         = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rec.queue_head[3:0];
          p_d     = rec.queue_head;
          n_d     = '0;
          state_d = S_ENQ_WALK;
        end
      end

      // walk to the queue tail and append the caller
      S_ENQ_WALK: begin
        if (rec.queue_next >= irs_pkg::NO_LINK || n_q == 5'd16) begin
          we               = 1'b1;
          waddr            = p_q[3:0];
          wdata.queue_next = {1'b0, caller_q};
          sts_d            = irs_pkg::STS_BLOCKED;
          ok_d             = irs_pkg::STS_BLOCKED;
          fail_d           = irs_pkg::STS_BLOCKED;
          go_sched         = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rec.queue_next[3:0];
          p_d     = rec.queue_next;
          n_d     = n_q + 5'd1;
        end
      end

      // receive: interrupt first, then a queued sender, else block
      S_RCV_CHK: begin
        caller_rec_d          = rec;
        blk_rec               = rec;
        blk_rec.proc_state    = irs_pkg::PS_RECV;
        blk_rec.recv_source   = peer_q;
        state_d               = S_OUT;
        if (rec.proc_state == irs_pkg::PS_RUN) begin
          if (rec.int_pending && (peer_q == irs_pkg::PEER_ANY ||
                                  peer_q == irs_pkg::PEER_INT)) begin
            we                = 1'b1;
            waddr             = caller_q;
            wdata.int_pending = 1'b0;
            sts_d             = irs_pkg::STS_INT;
            from_d            = irs_pkg::PEER_INT;
            to_d              = caller_q;
          end else if (peer_q == irs_pkg::PEER_ANY &&
                       rec.queue_head < irs_pkg::NO_LINK) begin
            src_d   = rec.queue_head[3:0];
            found_d = 1'b0;
            prev_d  = irs_pkg::NO_LINK;
            p_d     = rec.queue_head;
            n_d     = '0;
            rd_en   = 1'b1;
            rd_addr = rec.queue_head[3:0];
            state_d = S_UNL;
          end else if (peer_q < irs_pkg::NO_LINK) begin
            rd_en   = 1'b1;
            rd_addr = peer_q[3:0];
            state_d = S_RCV_PEER;
          end else begin
            we       = 1'b1;
            waddr    = caller_q;
            wdata    = blk_rec;
            sts_d    = irs_pkg::STS_BLOCKED;
            ok_d     = irs_pkg::STS_BLOCKED;
            fail_d   = irs_pkg::STS_BLOCKED;
            go_sched = 1'b1;
          end
        end
      end

      S_RCV_PEER: begin
        blk_rec.proc_state  = irs_pkg::PS_RECV;
        blk_rec.recv_source = peer_q;
        if (rec.proc_state == irs_pkg::PS_SEND && rec.send_target == caller_q) begin
          src_d   = peer_q[3:0];
          found_d = 1'b0;
          prev_d  = irs_pkg::NO_LINK;
          p_d     = caller_rec_q.queue_head;
          n_d     = '0;
          rd_en   = 1'b1;
          if (caller_rec_q.queue_head < irs_pkg::NO_LINK) begin
            rd_addr = caller_rec_q.queue_head[3:0];
            state_d = S_UNL;
          end else begin
            rd_addr = peer_q[3:0];
            state_d = S_SRC;
          end
        end else begin
          we       = 1'b1;
          waddr    = caller_q;
          wdata    = blk_rec;
          sts_d    = irs_pkg::STS_BLOCKED;
          ok_d     = irs_pkg::STS_BLOCKED;
          fail_d   = irs_pkg::STS_BLOCKED;
          go_sched = 1'b1;
        end
      end

      // unlink the sender from the caller's queue
      S_UNL: begin
        rd_addr = src_q;
        if (p_q[3:0] == src_q) begin
          found_d = 1'b1;
          we      = 1'b1;
          rd_en   = 1'b1;
          state_d = S_SRC;
          if (prev_q >= irs_pkg::NO_LINK) begin
            waddr            = caller_q;
            wdata            = caller_rec_q;
            wdata.queue_head = rec.queue_next;
          end else begin
            waddr            = prev_q[3:0];
            wdata            = prev_rec_q;
            wdata.queue_next = rec.queue_next;
          end
        end else begin
          prev_d     = p_q;
          prev_rec_d = rec;
          p_d        = rec.queue_next;
          n_d        = n_q + 5'd1;
          rd_en      = 1'b1;
          if (n_q == 5'd15 || rec.queue_next >= irs_pkg::NO_LINK) begin
            state_d = S_SRC;
          end else begin
            rd_addr = rec.queue_next[3:0];
          end
        end
      end

      // release the sender and hand over its tag
      S_SRC: begin
        we                = 1'b1;
        waddr             = src_q;
        wdata.proc_state  = irs_pkg::PS_RUN;
        wdata.send_target = '0;
        if (found_q) begin
          wdata.queue_next = irs_pkg::NO_LINK;
        end
        sts_d   = irs_pkg::STS_DELIVERED;
        from_d  = {1'b0, src_q};
        to_d    = caller_q;
        dtag_d  = rec.buffer_tag;
        state_d = S_OUT;
      end

      // scheduler scan for the most ticks
      S_SCAN: begin
        if (rec.proc_state == irs_pkg::PS_RUN && rec.tick_left > best_q) begin
          best_n = rec.tick_left;
          who_n  = idx_q;
        end
        best_d = best_n;
        who_d  = who_n;
        if (idx_q == LAST_PID) begin
          if (best_n != '0) begin
            running_d = who_n;
            sts_d     = ok_q;
            state_d   = S_OUT;
          end else if (!pass_q) begin
            pass_d  = 1'b1;
            idx_d   = '0;
            rd_en   = 1'b1;
            state_d = S_REFILL;
          end else begin
            sts_d   = fail_q;
            state_d = S_OUT;
          end
        end else begin
          idx_d   = idx_q + 4'd1;
          rd_en   = 1'b1;
          rd_addr = idx_q + 4'd1;
        end
      end

      // refill runnable ticks from priority
      S_REFILL: begin
        if (rec.proc_state == irs_pkg::PS_RUN) begin
          we              = 1'b1;
          waddr           = idx_q;
          wdata.tick_left = rec.prio;
        end
        rd_en = 1'b1;
        if (idx_q == LAST_PID) begin
          idx_d   = '0;
          best_d  = '0;
          who_d   = '0;
          state_d = S_SCAN;
        end else begin
          idx_d   = idx_q + 4'd1;
          rd_addr = idx_q + 4'd1;
        end
      end

      // hand the result to the output register
      S_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_d     = {running_q, dtag_q, to_q, from_q, sts_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // start a scheduler pass
    if (go_sched) begin
      idx_d   = '0;
      best_d  = '0;
      who_d   = '0;
      pass_d  = 1'b0;
      rd_en   = 1'b1;
      rd_addr = '0;
      state_d = S_SCAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      running_q <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    caller_q     <= caller_d;
    peer_q       <= peer_d;
    tag_q        <= tag_d;
    value_q      <= value_d;
    caller_rec_q <= caller_rec_d;
    prev_rec_q   <= prev_rec_d;
    p_q          <= p_d;
    prev_q       <= prev_d;
    n_q          <= n_d;
    src_q        <= src_d;
    idx_q        <= idx_d;
    who_q        <= who_d;
    best_q       <= best_d;
    pass_q       <= pass_d;
    found_q      <= found_d;
    ok_q         <= ok_d;
    fail_q       <= fail_d;
    sts_q        <= sts_d;
    from_q       <= from_d;
    to_q         <= to_d;
    dtag_q       <= dtag_d;
  end

  // a written entry is valid from then on
  a_write_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> vld_q[$past(waddr)])
    else $error("written record not marked valid");

  // the scheduler only ever picks an existing process
  a_running_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q <= LAST_PID)
    else $error("running process out of range");

  // an accepted command is dispatched next
  a_accept_disp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_take |=> state_q == S_DISP)
    else $error("accepted command not dispatched");

endmodule

>>> dv/tb_ipc_rendezvous_scheduler.sv
// tb_ipc_rendezvous_scheduler: stream-level testbench for the rendezvous engine
// predicts each result from its own process table and checks it field by field
// depends on irs_pkg and ipc_rendezvous_scheduler
module tb_ipc_rendezvous_scheduler;

  localparam int unsigned NTASK = 4;
  localparam int unsigned NUSER = 12;
  localparam int unsigned NPROC = (NTASK + NUSER > 16) ? 16 : NTASK + NUSER;

  // fields from the top bit down, so status sits in the lowest bits
  typedef struct packed {
    logic [3:0]  ready_pid;
    logic [15:0] dtag;
    logic [3:0]  to_pid;
    logic [4:0]  from_pid;
    logic [2:0]  status;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  ipc_rendezvous_scheduler #(.NUM_TASKS(NTASK), .NUM_USER(NUSER)) uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted process table
  logic [1:0]  p_state [16];
  logic [3:0]  p_target [16];
  logic [4:0]  p_source [16];
  logic        p_intr [16];
  logic [4:0]  p_head [16];
  logic [4:0]  p_next [16];
  logic [15:0] p_tag [16];
  logic [7:0]  p_ticks [16];
  logic [7:0]  p_prio [16];
  logic [3:0]  cur_pid;

  reply_t replies_due [$];
  int     n_errors = 0;
  int     hold_cnt = 0;

  // choose the runnable process with most ticks, refilling once
  function automatic bit choose_runner();
    int best, who;
    for (int pass = 0; pass < 2; pass++) begin
      best = 0; who = 0;
      for (int i = 0; i < NPROC; i++)
        if (p_state[i] == irs_pkg::PS_RUN && p_ticks[i] > best) begin
          best = p_ticks[i]; who = i;
        end
      if (best > 0) begin
        cur_pid = who[3:0];
        return 1'b1;
      end
      if (pass == 0)
        for (int i = 0; i < NPROC; i++)
          if (p_state[i] == irs_pkg::PS_RUN) p_ticks[i] = p_prio[i];
    end
    return 1'b0;
  endfunction

  function automatic bit wait_cycle(int src, int dest);
    int p;
    p = dest & 15;
    for (int n = 0; n < 16; n++) begin
      if (p_state[p] != irs_pkg::PS_SEND) return 1'b0;
      if (p_target[p] == src) return 1'b1;
      p = p_target[p];
    end
    return 1'b0;
  endfunction

  function automatic void queue_sender(int dest, int who);
    int p;
    p_next[who] = irs_pkg::NO_LINK;
    if (p_head[dest] >= irs_pkg::NO_LINK) begin
      p_head[dest] = who[4:0];
      return;
    end
    p = p_head[dest];
    for (int n = 0; n < 16; n++) begin
      if (p_next[p] >= irs_pkg::NO_LINK) break;
      p = p_next[p];
    end
    p_next[p] = who[4:0];
  endfunction

  function automatic void dequeue_sender(int owner, int who);
    int prev, p;
    prev = irs_pkg::NO_LINK; p = p_head[owner];
    for (int n = 0; n < 16 && p < irs_pkg::NO_LINK; n++) begin
      if (p == who) begin
        if (prev >= irs_pkg::NO_LINK) p_head[owner] = p_next[p];
        else p_next[prev] = p_next[p];
        p_next[p] = irs_pkg::NO_LINK;
        return;
      end
      prev = p;
      p = p_next[p];
    end
  endfunction

  // work out the reply to one command and update the table
  function automatic reply_t predict_reply(logic [2:0] cmd, int caller, int peer,
                                           logic [15:0] tag, logic [7:0] val);
    reply_t r;
    bit ok, peer_ok;
    int src, q;
    r = '0;
    r.status = irs_pkg::STS_DONE;
    ok = caller < NPROC;
    case (cmd)
      irs_pkg::CMD_SEND: begin
        if (ok && p_state[caller] == irs_pkg::PS_RUN && peer < NPROC && peer != caller) begin
          if (wait_cycle(caller, peer)) begin
            r.status = irs_pkg::STS_DEADLOCK;
          end else if (p_state[peer] == irs_pkg::PS_RECV &&
                       (p_source[peer] == caller ||
                        p_source[peer] == irs_pkg::PEER_ANY)) begin
            p_state[peer] = irs_pkg::PS_RUN; p_source[peer] = '0;
            r.status = irs_pkg::STS_DELIVERED;
            r.from_pid = 5'(caller); r.to_pid = 4'(peer);
            r.dtag = tag;
          end else begin
            p_state[caller] = irs_pkg::PS_SEND; p_target[caller] = 4'(peer);
            p_tag[caller] = tag;
            queue_sender(peer, caller);
            void'(choose_runner());
            r.status = irs_pkg::STS_BLOCKED;
          end
        end
      end
      irs_pkg::CMD_RECV: begin
        peer_ok = peer == irs_pkg::PEER_ANY || peer == irs_pkg::PEER_INT ||
                  (peer < NPROC && peer != caller);
        if (ok && p_state[caller] == irs_pkg::PS_RUN && peer_ok) begin
          src = irs_pkg::NO_LINK;
          if (p_intr[caller] && (peer == irs_pkg::PEER_ANY || peer == irs_pkg::PEER_INT)) begin
            p_intr[caller] = 1'b0;
            r.status = irs_pkg::STS_INT; r.from_pid = irs_pkg::PEER_INT;
            r.to_pid = 4'(caller);
          end else begin
            if (peer == irs_pkg::PEER_ANY) begin
              if (p_head[caller] < irs_pkg::NO_LINK) src = p_head[caller];
            end else if (peer < 16) begin
              if (p_state[peer] == irs_pkg::PS_SEND && p_target[peer] == caller) src = peer;
            end
            if (src < irs_pkg::NO_LINK) begin
              dequeue_sender(caller, src);
              p_state[src] = irs_pkg::PS_RUN; p_target[src] = '0;
              r.status = irs_pkg::STS_DELIVERED;
              r.from_pid = 5'(src); r.to_pid = 4'(caller);
              r.dtag = p_tag[src];
            end else begin
              p_state[caller] = irs_pkg::PS_RECV; p_source[caller] = 5'(peer);
              void'(choose_runner());
              r.status = irs_pkg::STS_BLOCKED;
            end
          end
        end
      end
      irs_pkg::CMD_SCHED:
        r.status = choose_runner() ? irs_pkg::STS_DONE : irs_pkg::STS_IDLE_ALL;
      irs_pkg::CMD_POST: begin
        if (ok) begin
          if (p_state[caller] == irs_pkg::PS_RECV &&
              (p_source[caller] == irs_pkg::PEER_ANY ||
               p_source[caller] == irs_pkg::PEER_INT)) begin
            p_state[caller] = irs_pkg::PS_RUN; p_source[caller] = '0;
            r.status = irs_pkg::STS_INT; r.from_pid = irs_pkg::PEER_INT;
            r.to_pid = 4'(caller);
          end else begin
            p_intr[caller] = 1'b1;
          end
        end
      end
      irs_pkg::CMD_LOAD: if (ok) p_prio[caller] = val;
      irs_pkg::CMD_TICK: begin
        q = cur_pid;
        if (p_ticks[q] > 0) begin
          p_ticks[q]--;
          if (p_ticks[q] == 0 && !choose_runner()) r.status = irs_pkg::STS_IDLE_ALL;
        end
      end
      default: ;
    endcase
    r.ready_pid = cur_pid;
    return r;
  endfunction

  // random gap, mostly short, sometimes long
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  bit idle_mode = 1'b0;

  // send one command and queue its predicted reply
  task automatic send_cmd(logic [2:0] cmd, logic [3:0] caller, logic [4:0] peer,
                          logic [15:0] tag, logic [7:0] val);
    int g;
    g = idle_mode ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata  <= {4'b0, val, tag, peer, caller, cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    replies_due.push_back(predict_reply(cmd, caller, peer, tag, val));
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    reply_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (replies_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"mismatch: expected st=%0d from=%0d to=%0d tag=%h run=%0d, ",
                      "got st=%0d from=%0d to=%0d tag=%h run=%0d"},
                     want.status, want.from_pid, want.to_pid, want.dtag, want.ready_pid,
                     got.status, got.from_pid, got.to_pid, got.dtag, got.ready_pid);
        end
      end
    end
  end

  // result back-pressure, stalls mostly short and a few long
  always @(negedge clk_i) begin
    int g;
    if (idle_mode) begin
      m_axis_tready <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      g = gap_len();
      if (g > 0) begin
        hold_cnt = g - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [4:0] rand_peer();
    return $urandom_range(0, 9) == 0 ? 5'($urandom_range(16, 31))
                                     : 5'($urandom_range(0, 17));
  endfunction

  // field extremes, ignored commands and simple interrupts
  task automatic test_directed_basics();
    send_cmd(irs_pkg::CMD_SCHED, 4'd0, 5'd0, 16'h0000, 8'h00);
    send_cmd(irs_pkg::CMD_TICK, 4'd0, 5'd0, 16'h0000, 8'h00);
    send_cmd(3'd6, 4'd15, 5'd31, 16'hffff, 8'hff);
    send_cmd(3'd7, 4'd3, 5'd5, 16'h1234, 8'h55);
    send_cmd(irs_pkg::CMD_LOAD, 4'd0, 5'd0, 16'h0, 8'hff);
    send_cmd(irs_pkg::CMD_LOAD, 4'd1, 5'd0, 16'h0, 8'h01);
    send_cmd(irs_pkg::CMD_LOAD, 4'd15, 5'd0, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_SEND, 4'd2, 5'd2, 16'hffff, 8'h00);
    send_cmd(irs_pkg::CMD_SEND, 4'd2, 5'd16, 16'hffff, 8'h00);
    send_cmd(irs_pkg::CMD_RECV, 4'd3, 5'd31, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_POST, 4'd4, 5'd0, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_RECV, 4'd4, irs_pkg::PEER_INT, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_RECV, 4'd5, irs_pkg::PEER_ANY, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_POST, 4'd5, 5'd0, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_SCHED, 4'd0, 5'd0, 16'h0, 8'h00);
  endtask

  // rendezvous, queued senders and a refused deadlock
  task automatic test_directed_rendezvous();
    send_cmd(irs_pkg::CMD_RECV, 4'd6, 5'd7, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_SEND, 4'd7, 5'd6, 16'hbeef, 8'h00);
    send_cmd(irs_pkg::CMD_SEND, 4'd8, 5'd9, 16'h0001, 8'h00);
    send_cmd(irs_pkg::CMD_SEND, 4'd10, 5'd9, 16'h0002, 8'h00);
    send_cmd(irs_pkg::CMD_SEND, 4'd9, 5'd8, 16'h0003, 8'h00);
    send_cmd(irs_pkg::CMD_RECV, 4'd9, 5'd10, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_RECV, 4'd9, irs_pkg::PEER_ANY, 16'h0, 8'h00);
    send_cmd(irs_pkg::CMD_TICK, 4'd0, 5'd0, 16'h0, 8'h00);
  endtask

  // well-formed mixes with random content and some noise
  task automatic test_random_traffic(int n);
    logic [2:0] cmd;
    int k;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) idle_mode = $urandom_range(0, 3) == 0;
      k = $urandom_range(0, 99);
      if (k < 28)      cmd = irs_pkg::CMD_SEND;
      else if (k < 50) cmd = irs_pkg::CMD_RECV;
      else if (k < 60) cmd = irs_pkg::CMD_SCHED;
      else if (k < 70) cmd = irs_pkg::CMD_POST;
      else if (k < 80) cmd = irs_pkg::CMD_LOAD;
      else if (k < 96) cmd = irs_pkg::CMD_TICK;
      else             cmd = 3'($urandom_range(6, 7));
      send_cmd(cmd, 4'($urandom_range(0, 15)), rand_peer(),
               16'($urandom_range(0, 65535)),
               $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 4)));
    end
    idle_mode = 1'b0;
  endtask

  // main sequence
  initial begin
    for (int i = 0; i < 16; i++) begin
      p_state[i] = irs_pkg::PS_RUN; p_target[i] = '0; p_source[i] = '0;
      p_intr[i] = 1'b0;
      p_head[i] = irs_pkg::NO_LINK; p_next[i] = irs_pkg::NO_LINK; p_tag[i] = '0;
      p_ticks[i] = '0; p_prio[i] = '0;
    end
    cur_pid = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_basics();
    test_directed_rendezvous();
    test_random_traffic(430);
    s_axis_tvalid <= 1'b0;
    fork
      wait (replies_due.size() == 0);
      #200000;
    join_any
    disable fork;
    repeat (100) @(posedge clk_i);
    if (replies_due.size() == 0 && n_errors == 0) begin
      $display("tb_ipc_rendezvous_scheduler: clean");
    end else begin
      $display("tb_ipc_rendezvous_scheduler: errors");
    end
    $finish;
  end

  // run time limit
  initial begin
    #5000000;
    $display("tb_ipc_rendezvous_scheduler: errors");
    $finish;
  end

endmodule
